// ----- src/eeseq_pkg.sv -----
package eeseq_pkg;

    // Field widths
    localparam int CMD_W     = 2;
    localparam int PAGE_W    = 3;
    localparam int BYTE_W    = 8;
    localparam int TIME_W    = 32;
    localparam int DELAY_W   = 20;
    localparam int ERR_W     = 10;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 20;

    // Request codes
    localparam logic [CMD_W-1:0] CMD_STEP  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Engine commands
    localparam logic [OP_W-1:0] OP_NONE  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_SEND  = 2'd2;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd3;

    // Device addresses
    localparam logic [BYTE_W-1:0] DEV_WRITE = 8'hA0;
    localparam logic [BYTE_W-1:0] DEV_READ  = 8'hA1;

    // I2C master status codes
    localparam logic [BYTE_W-1:0] ST_BUSY     = 8'h00;
    localparam logic [BYTE_W-1:0] ST_START    = 8'h08;
    localparam logic [BYTE_W-1:0] ST_RESTART  = 8'h10;
    localparam logic [BYTE_W-1:0] ST_SLA_W    = 8'h18;
    localparam logic [BYTE_W-1:0] ST_DATA_ACK = 8'h28;
    localparam logic [BYTE_W-1:0] ST_SLA_R    = 8'h40;
    localparam logic [BYTE_W-1:0] ST_DATA_NAK = 8'h58;

    // Error bases for the write sequence
    localparam logic [ERR_W-1:0] ERR_NONE  = 10'd0;
    localparam logic [ERR_W-1:0] ERR_START = 10'd100;
    localparam logic [ERR_W-1:0] ERR_DEV   = 10'd200;
    localparam logic [ERR_W-1:0] ERR_ADDR  = 10'd300;
    localparam logic [ERR_W-1:0] ERR_DATA  = 10'd400;

    // Register map
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ENABLE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_STOP_DELAY = 2'd1;

    localparam logic [DELAY_W-1:0] STOP_DELAY_RESET = 20'd5000;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [PAGE_W-1:0] page;
        logic [BYTE_W-1:0] mem_address;
        logic [BYTE_W-1:0] write_value;
        logic [TIME_W-1:0] now_us;
        logic              bus_grant;
        logic              engine_ready;
        logic [BYTE_W-1:0] engine_status;
        logic [BYTE_W-1:0] engine_rx_byte;
    } req_item_t;

    typedef struct packed {
        logic              request_accepted;
        logic [OP_W-1:0]   engine_op;
        logic [BYTE_W-1:0] engine_tx_byte;
        logic              busy_res;
        logic              data_ready;
        logic [BYTE_W-1:0] read_result;
        logic [ERR_W-1:0]  first_error;
    } rsp_item_t;

    typedef struct packed {
        logic               enable;
        logic [DELAY_W-1:0] stop_delay_us;
    } cfg_t;

endpackage

// ----- src/eeseq_if.sv -----
interface eeseq_req_if;
    import eeseq_pkg::*;
    logic      valid;
    logic      ready;
    req_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface eeseq_rsp_if;
    import eeseq_pkg::*;
    logic      valid;
    logic      ready;
    rsp_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface eeseq_cfg_if;
    import eeseq_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

// ----- src/eeseq_cfg_regs.sv -----
module eeseq_cfg_regs
    import eeseq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_DAT_W-1:0] wr_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            // Indexes beyond the map are dropped
            if (wr_index == CFG_IDX_ENABLE)
                cfg_next.enable = wr_data[0];
            else if (wr_index == CFG_IDX_STOP_DELAY)
                cfg_next.stop_delay_us = wr_data[DELAY_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable        <= 1'b0;
            cfg_reg.stop_delay_us <= STOP_DELAY_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/eeseq_core.sv -----
module eeseq_core
    import eeseq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      take,
    input  req_item_t item,
    output rsp_item_t result
);

    typedef enum logic [4:0] {
        PH_IDLE          = 5'd0,
        PH_W_START       = 5'd1,
        PH_W_START_ACK   = 5'd2,
        PH_W_DEV         = 5'd3,
        PH_W_DEV_ACK     = 5'd4,
        PH_W_ADDR        = 5'd5,
        PH_W_ADDR_ACK    = 5'd6,
        PH_W_DATA        = 5'd7,
        PH_W_DATA_ACK    = 5'd8,
        PH_STOP          = 5'd9,
        PH_R_START       = 5'd10,
        PH_R_START_ACK   = 5'd11,
        PH_R_DEV         = 5'd12,
        PH_R_DEV_ACK     = 5'd13,
        PH_R_ADDR        = 5'd14,
        PH_R_ADDR_ACK    = 5'd15,
        PH_R_RESTART     = 5'd16,
        PH_R_RESTART_ACK = 5'd17,
        PH_R_DEVRD       = 5'd18,
        PH_R_DEVRD_ACK   = 5'd19,
        PH_R_DATA        = 5'd20,
        PH_R_DATA_ACK    = 5'd21
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] block_bits_reg, block_bits_next;
    logic [BYTE_W-1:0] target_address_reg, target_address_next;
    logic [BYTE_W-1:0] pending_value_reg, pending_value_next;
    logic [TIME_W-1:0] last_stop_time_reg, last_stop_time_next;
    logic              ready_flag_reg, ready_flag_next;
    logic [BYTE_W-1:0] latched_byte_reg, latched_byte_next;
    logic [ERR_W-1:0]  error_record_reg, error_record_next;

    logic [TIME_W-1:0] elapsed;
    logic              delay_met;
    logic              ack_chk;
    logic [BYTE_W-1:0] ack_expect;
    phase_t            ack_target;
    logic [ERR_W-1:0]  ack_base;
    logic              accepted;
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] tx;

    assign elapsed   = item.now_us - last_stop_time_reg;
    assign delay_met = elapsed >= {{(TIME_W-DELAY_W){1'b0}}, cfg.stop_delay_us};

    always_comb
    begin
        phase_next          = phase_reg;
        block_bits_next     = block_bits_reg;
        target_address_next = target_address_reg;
        pending_value_next  = pending_value_reg;
        last_stop_time_next = last_stop_time_reg;
        ready_flag_next     = ready_flag_reg;
        latched_byte_next   = latched_byte_reg;
        error_record_next   = error_record_reg;
        accepted            = 1'b0;
        op                  = OP_NONE;
        tx                  = '0;
        ack_chk             = 1'b0;
        ack_expect          = ST_BUSY;
        ack_target          = PH_IDLE;
        ack_base            = ERR_NONE;

        if (cfg.enable && (item.cmd == CMD_WRITE || item.cmd == CMD_READ))
        begin
            if (phase_reg == PH_IDLE && delay_met && item.bus_grant)
            begin
                accepted            = 1'b1;
                block_bits_next     = {{(BYTE_W-PAGE_W-1){1'b0}}, item.page, 1'b0};
                target_address_next = item.mem_address;
                if (item.cmd == CMD_WRITE)
                begin
                    pending_value_next = item.write_value;
                    phase_next         = PH_W_START;
                end
                else
                begin
                    pending_value_next = '0;
                    ready_flag_next    = 1'b0;
                    phase_next         = PH_R_START;
                end
            end
        end
        else if (cfg.enable && item.cmd == CMD_STEP)
        begin
            unique case (phase_reg)
                PH_W_START, PH_R_START, PH_R_RESTART:
                begin
                    if (item.engine_ready)
                    begin
                        op = OP_START;
                        phase_next = phase_t'(phase_reg + 5'd1);
                    end
                end
                PH_W_DEV, PH_R_DEV:
                begin
                    if (item.engine_ready)
                    begin
                        op = OP_SEND;
                        tx = DEV_WRITE + block_bits_reg;
                        phase_next = phase_t'(phase_reg + 5'd1);
                    end
                end
                PH_W_ADDR, PH_R_ADDR:
                begin
                    if (item.engine_ready)
                    begin
                        op = OP_SEND;
                        tx = target_address_reg;
                        phase_next = phase_t'(phase_reg + 5'd1);
                    end
                end
                PH_W_DATA:
                begin
                    if (item.engine_ready)
                    begin
                        op = OP_SEND;
                        tx = pending_value_reg;
                        phase_next = PH_W_DATA_ACK;
                    end
                end
                PH_R_DEVRD:
                begin
                    if (item.engine_ready)
                    begin
                        op = OP_SEND;
                        tx = DEV_READ + block_bits_reg;
                        phase_next = PH_R_DEVRD_ACK;
                    end
                end
                PH_R_DATA:
                begin
                    // Clock in the data byte; the tx byte stays zero here
                    if (item.engine_ready)
                    begin
                        op = OP_SEND;
                        phase_next = PH_R_DATA_ACK;
                    end
                end
                PH_STOP:
                begin
                    if (item.engine_ready)
                    begin
                        op = OP_STOP;
                        phase_next = PH_IDLE;
                        last_stop_time_next = item.now_us;
                    end
                end
                PH_W_START_ACK:
                begin
                    ack_chk = 1'b1; ack_expect = ST_START;
                    ack_target = PH_W_DEV; ack_base = ERR_START;
                end
                PH_W_DEV_ACK:
                begin
                    ack_chk = 1'b1; ack_expect = ST_SLA_W;
                    ack_target = PH_W_ADDR; ack_base = ERR_DEV;
                end
                PH_W_ADDR_ACK:
                begin
                    ack_chk = 1'b1; ack_expect = ST_DATA_ACK;
                    ack_target = PH_W_DATA; ack_base = ERR_ADDR;
                end
                PH_W_DATA_ACK:
                begin
                    ack_chk = 1'b1; ack_expect = ST_DATA_ACK;
                    ack_target = PH_STOP; ack_base = ERR_DATA;
                end
                PH_R_START_ACK:
                begin
                    ack_chk = 1'b1; ack_expect = ST_START; ack_target = PH_R_DEV;
                end
                PH_R_DEV_ACK:
                begin
                    ack_chk = 1'b1; ack_expect = ST_SLA_W; ack_target = PH_R_ADDR;
                end
                PH_R_ADDR_ACK:
                begin
                    ack_chk = 1'b1; ack_expect = ST_DATA_ACK; ack_target = PH_R_RESTART;
                end
                PH_R_RESTART_ACK:
                begin
                    ack_chk = 1'b1; ack_expect = ST_RESTART; ack_target = PH_R_DEVRD;
                end
                PH_R_DEVRD_ACK:
                begin
                    ack_chk = 1'b1; ack_expect = ST_SLA_R; ack_target = PH_R_DATA;
                end
                PH_R_DATA_ACK:
                begin
                    if (item.engine_status == ST_DATA_NAK)
                    begin
                        latched_byte_next = item.engine_rx_byte;
                        ready_flag_next   = 1'b1;
                        phase_next        = PH_STOP;
                    end
                    else if (item.engine_status != ST_BUSY)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase

            // Shared acknowledge check: wait on busy, advance on match, else abort
            if (ack_chk && item.engine_status != ST_BUSY)
            begin
                if (item.engine_status == ack_expect)
                begin
                    phase_next = ack_target;
                end
                else
                begin
                    if (ack_base != ERR_NONE && error_record_reg == ERR_NONE)
                        error_record_next = ack_base
                                            + {{(ERR_W-BYTE_W){1'b0}}, item.engine_status};
                    phase_next = PH_IDLE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            block_bits_reg     <= '0;
            target_address_reg <= '0;
            pending_value_reg  <= '0;
            last_stop_time_reg <= '0;
            ready_flag_reg     <= 1'b0;
            latched_byte_reg   <= '0;
            error_record_reg   <= ERR_NONE;
        end
        else if (take)
        begin
            phase_reg          <= phase_next;
            block_bits_reg     <= block_bits_next;
            target_address_reg <= target_address_next;
            pending_value_reg  <= pending_value_next;
            last_stop_time_reg <= last_stop_time_next;
            ready_flag_reg     <= ready_flag_next;
            latched_byte_reg   <= latched_byte_next;
            error_record_reg   <= error_record_next;
        end
    end

    always_comb
    begin
        result.request_accepted = accepted;
        result.engine_op        = op;
        result.engine_tx_byte   = tx;
        result.busy_res         = (phase_next != PH_IDLE);
        result.data_ready       = ready_flag_next;
        result.read_result      = latched_byte_next;
        result.first_error      = error_record_next;
    end

endmodule

// ----- src/eeseq_out_stage.sv -----
module eeseq_out_stage
    import eeseq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  rsp_item_t push_data,
    output logic      space,
    output logic      out_valid,
    input  logic      out_ready,
    output rsp_item_t out_data
);

    logic      main_valid_reg;
    logic      skid_valid_reg;
    rsp_item_t main_reg;
    rsp_item_t skid_reg;
    logic      pop;

    assign pop       = main_valid_reg && out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else if (!push)
                main_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (main_valid_reg)
                skid_valid_reg <= 1'b1;
            else
                main_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
                main_reg <= skid_reg;
            else if (push)
                main_reg <= push_data;
        end
        else if (push)
        begin
            if (main_valid_reg)
                skid_reg <= push_data;
            else
                main_reg <= push_data;
        end
    end

endmodule

// ----- src/eeprom_i2c_byte_transaction_sequencer.sv -----
// Channel  Dir  Payload                                         Handshake
// req      in   cmd, page, address, data, time, engine status   valid/ready
// rsp      out  accepted, engine command and byte, status       valid/ready
// cfg      in   register index, write data                      valid/ready
//
// Each req item is decided combinationally: the phase logic reads the item and
// the held transaction state, and writes the new state and the rsp item at
// the same edge. One item per cycle is sustained while rsp is drained.
// A two-entry output buffer (main plus skid) decouples req.ready from
// rsp.ready; req stalls only when both entries are full.
// Reset clears the phase, the transaction state and the registers
// (enable off, stop delay 5000 us). cfg is always ready.
module eeprom_i2c_byte_transaction_sequencer
    import eeseq_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    eeseq_req_if.sink   req,
    eeseq_rsp_if.source rsp,
    eeseq_cfg_if.sink   cfg
);

    cfg_t      cfg_q;
    rsp_item_t core_result;
    logic      space;
    logic      take;

    // Registers are written without back-pressure
    assign cfg.ready = 1'b1;

    // Accept a request item whenever the output buffer has a free entry
    assign req.ready = space;
    assign take      = req.valid && space;

    eeseq_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.wdata),
        .cfg      (cfg_q)
    );

    // Advance the transaction phase once per accepted item
    eeseq_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_q),
        .take   (take),
        .item   (req.data),
        .result (core_result)
    );

    // Hold results until the consumer takes them
    eeseq_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .push_data (core_result),
        .space     (space),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_data  (rsp.data)
    );

endmodule

// ----- src/eeseq_checker.sv -----
module eeseq_checker
    import eeseq_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input rsp_item_t rsp_data
);

    // A stalled item holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("rsp item changed while stalled");

    // A byte goes out only with a send command
    a_tx_only_send: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.engine_op != OP_SEND |-> rsp_data.engine_tx_byte == 8'h00)
        else $error("tx byte without send command");

    // A taken request issues no command and leaves the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.request_accepted
        |-> rsp_data.engine_op == OP_NONE && rsp_data.busy_res)
        else $error("accepted request with command or idle");

    // A stop ends the transaction
    a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.engine_op == OP_STOP |-> !rsp_data.busy_res)
        else $error("busy after stop");

endmodule

bind eeprom_i2c_byte_transaction_sequencer eeseq_checker u_eeseq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);
